@@ hdl/acds_pkg.sv @@
// ----------------------------------------------------------------------------
// acds_pkg
// Shared types, constants and table functions for the audio clock divider
// search: ratio and divider grids, sequencer states and the step record.
// ----------------------------------------------------------------------------
package acds_pkg;

   localparam int unsigned RATE_W    = 20;
   localparam int unsigned WIDTH_W   = 6;
   localparam int unsigned IDX_W     = 4;
   localparam int unsigned RATIO_W   = 10;
   localparam int unsigned DIV_W     = 7;
   localparam int unsigned RR_W      = RATE_W + RATIO_W;
   localparam int unsigned PROD_W    = RR_W + DIV_W;
   localparam int unsigned ERR_W     = 25;

   localparam logic [ERR_W-1:0]   MASTER_CLK      = ERR_W'(32000000);
   localparam logic [WIDTH_W-1:0] WIDTH_RESET     = WIDTH_W'(16);
   localparam logic [IDX_W-1:0]   LAST_RATIO_IDX  = IDX_W'(8);
   localparam logic [IDX_W-1:0]   LAST_DIV_IDX    = IDX_W'(12);

   typedef enum logic [1:0] {
      ACDS_IDLE,
      ACDS_RUN,
      ACDS_DRAIN,
      ACDS_HOLD
   } state_type;

   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last;
      logic [IDX_W-1:0] r_idx;
      logic [IDX_W-1:0] d_idx;
   } step_type;

   typedef struct packed {
      logic ready;
      logic load;
   } seq_status_type;

   function automatic logic [RATIO_W-1:0] ratio_val(input logic [IDX_W-1:0] idx);
      logic [RATIO_W-1:0] v;
      case (idx)
         4'd0:    v = RATIO_W'(32);
         4'd1:    v = RATIO_W'(48);
         4'd2:    v = RATIO_W'(64);
         4'd3:    v = RATIO_W'(96);
         4'd4:    v = RATIO_W'(128);
         4'd5:    v = RATIO_W'(192);
         4'd6:    v = RATIO_W'(256);
         4'd7:    v = RATIO_W'(384);
         4'd8:    v = RATIO_W'(512);
         default: v = '0;
      endcase
      return v;
   endfunction

   // ratio = odd * 2**exp with odd in {1, 3}
   function automatic logic ratio_odd3(input logic [IDX_W-1:0] idx);
      return idx[0];
   endfunction

   function automatic logic [3:0] ratio_exp(input logic [IDX_W-1:0] idx);
      logic [3:0] e;
      case (idx)
         4'd0:    e = 4'd5;
         4'd1:    e = 4'd4;
         4'd2:    e = 4'd6;
         4'd3:    e = 4'd5;
         4'd4:    e = 4'd7;
         4'd5:    e = 4'd6;
         4'd6:    e = 4'd8;
         4'd7:    e = 4'd7;
         4'd8:    e = 4'd9;
         default: e = 4'd0;
      endcase
      return e;
   endfunction

   function automatic logic [DIV_W-1:0] div_val(input logic [IDX_W-1:0] idx);
      logic [DIV_W-1:0] v;
      case (idx)
         4'd0:    v = DIV_W'(8);
         4'd1:    v = DIV_W'(10);
         4'd2:    v = DIV_W'(11);
         4'd3:    v = DIV_W'(15);
         4'd4:    v = DIV_W'(16);
         4'd5:    v = DIV_W'(21);
         4'd6:    v = DIV_W'(23);
         4'd7:    v = DIV_W'(30);
         4'd8:    v = DIV_W'(31);
         4'd9:    v = DIV_W'(32);
         4'd10:   v = DIV_W'(42);
         4'd11:   v = DIV_W'(63);
         4'd12:   v = DIV_W'(125);
         default: v = '0;
      endcase
      return v;
   endfunction

   // ratio is a multiple of 2*width (and hence at least 2*width)
   function automatic logic ratio_fits(input logic [IDX_W-1:0] idx,
                                       input logic [WIDTH_W-1:0] width);
      logic [2:0]         tz;
      logic [WIDTH_W-1:0] odd;
      logic               odd_ok;
      tz = '0;
      for (int i = WIDTH_W - 1; i >= 0; i--) begin
         if (width[i]) begin
            tz = 3'(i);
         end
      end
      odd    = width >> tz;
      odd_ok = (odd == WIDTH_W'(1)) || ((odd == WIDTH_W'(3)) && ratio_odd3(idx));
      return (width != '0) && odd_ok && ({1'b0, tz} + 4'd1 <= ratio_exp(idx));
   endfunction

endpackage

@@ hdl/audio_clock_divider_search.sv @@
// ----------------------------------------------------------------------------
// audio_clock_divider_search
// Finds the frame ratio and master-clock divider whose sample rate comes
// closest to a requested rate from above, for a 32 MHz master clock.
//
//   port group   dir   beat contents (low bits first)
//   req_*        in    req_rate[19:0]
//   rsp_*        out   divider_index[3:0], ratio_index[7:4], rate_error[32:8]
//   csr_*        in    sample_bits[5:0], written when csr_wen is high
//
// Each request walks all 117 grid pairs through the shared multiply/compare
// unit, one pair per cycle, then drains the evaluation pipeline and hands the
// result off. req_tready is high only while the sequencer is
// idle; a new request is accepted while a finished result waits in the rsp
// register. A stalled result holds the sequencer until the register frees.
// Synchronous reset sets sample_bits to 16 and empties the result register.
// ----------------------------------------------------------------------------
module audio_clock_divider_search
   import acds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // req_rate[19:0], zero [23:20]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // divider_index[3:0], ratio_index[7:4],
                                    // rate_error[32:8], zero [39:33]
   input  logic        csr_wen,
   input  logic [5:0]  csr_wdata    // sample_bits[5:0]
);

   logic [WIDTH_W-1:0] width_ff;
   logic [RATE_W-1:0]  rate_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_div_ff;
   logic [IDX_W-1:0]   rsp_ratio_ff;
   logic [ERR_W-1:0]   rsp_err_ff;

   step_type           step;
   seq_status_type     status;
   logic               start;
   logic               out_free;
   logic               eval_done;
   logic [IDX_W-1:0]   best_div;
   logic [IDX_W-1:0]   best_ratio;
   logic [ERR_W-1:0]   best_err;

   assign start    = req_tvalid && status.ready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            width_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rate_ff <= req_tdata[RATE_W-1:0];
      end
      if (status.load) begin
         rsp_div_ff   <= best_div;
         rsp_ratio_ff <= best_ratio;
         rsp_err_ff   <= best_err;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (status.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   acds_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .eval_done (eval_done),
      .out_free  (out_free),
      .step      (step),
      .status    (status)
   );

   acds_eval u_eval (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rate       (rate_ff),
      .width      (width_ff),
      .done       (eval_done),
      .best_div   (best_div),
      .best_ratio (best_ratio),
      .best_err   (best_err)
   );

   assign req_tready = status.ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_err_ff, rsp_ratio_ff, rsp_div_ff};

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while search still running");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_err_ff <= MASTER_CLK))
      else $error("rate error above master clock");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_div_ff <= LAST_DIV_IDX) && (rsp_ratio_ff <= LAST_RATIO_IDX)))
      else $error("result index outside grid");

   a_no_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_err_ff == MASTER_CLK)) |->
         ((rsp_div_ff == '0) && (rsp_ratio_ff == '0)))
      else $error("no-match result carries nonzero indices");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      status.load |-> out_free)
      else $error("result loaded over a pending beat");

endmodule

@@ hdl/acds_seq.sv @@
// ----------------------------------------------------------------------------
// acds_seq
// Sequencer: walks the ratio/divider grid one pair per cycle, waits for the
// evaluation pipeline to drain and hands the result to the output register.
// ----------------------------------------------------------------------------
module acds_seq
   import acds_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           eval_done,
   input  logic           out_free,
   output step_type       step,
   output seq_status_type status
);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] r_ff, r_in;
   logic [IDX_W-1:0] d_ff, d_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ACDS_IDLE;
         r_ff     <= '0;
         d_ff     <= '0;
      end else begin
         state_ff <= state_in;
         r_ff     <= r_in;
         d_ff     <= d_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      d_in         = d_ff;
      step         = '0;
      status.ready = 1'b0;
      status.load  = 1'b0;
      unique case (state_ff)
         ACDS_IDLE: begin
            status.ready = 1'b1;
            if (start) begin
               state_in = ACDS_RUN;
               r_in     = '0;
               d_in     = '0;
            end
         end
         ACDS_RUN: begin
            step.valid = 1'b1;
            step.first = (r_ff == '0) && (d_ff == '0);
            step.last  = (r_ff == LAST_RATIO_IDX) && (d_ff == LAST_DIV_IDX);
            step.r_idx = r_ff;
            step.d_idx = d_ff;
            if (d_ff == LAST_DIV_IDX) begin
               d_in = '0;
               if (r_ff == LAST_RATIO_IDX) begin
                  state_in = ACDS_DRAIN;
               end else begin
                  r_in = r_ff + IDX_W'(1);
               end
            end else begin
               d_in = d_ff + IDX_W'(1);
            end
         end
         ACDS_DRAIN: begin
            if (eval_done) begin
               if (out_free) begin
                  status.load = 1'b1;
                  state_in    = ACDS_IDLE;
               end else begin
                  state_in = ACDS_HOLD;
               end
            end
         end
         ACDS_HOLD: begin
            if (out_free) begin
               status.load = 1'b1;
               state_in    = ACDS_IDLE;
            end
         end
         default: state_in = ACDS_IDLE;
      endcase
   end

endmodule

@@ hdl/acds_eval.sv @@
// ----------------------------------------------------------------------------
// acds_eval
// Shared evaluation unit: two registered multiplies form rate*ratio*divider,
// then one subtract and compare keeps the best qualifying pair.
// ----------------------------------------------------------------------------
module acds_eval
   import acds_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  step_type           step,
   input  logic [RATE_W-1:0]  rate,
   input  logic [WIDTH_W-1:0] width,
   output logic               done,
   output logic [IDX_W-1:0]   best_div,
   output logic [IDX_W-1:0]   best_ratio,
   output logic [ERR_W-1:0]   best_err
);

   step_type          s1_ff, s2_ff;
   logic [RR_W-1:0]   rr_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              fits1_ff, fits2_ff;
   logic              done_ff;
   logic [IDX_W-1:0]  bd_ff, bd_in;
   logic [IDX_W-1:0]  br_ff, br_in;
   logic [ERR_W-1:0]  be_ff, be_in;

   logic [ERR_W-1:0]  base_err;
   logic [ERR_W-1:0]  cand_err;
   logic              in_range;
   logic              take;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_ff.valid <= step.valid;
         s2_ff.valid <= s1_ff.valid;
         done_ff     <= s2_ff.valid && s2_ff.last;
      end
      s1_ff.first <= step.first;
      s1_ff.last  <= step.last;
      s1_ff.r_idx <= step.r_idx;
      s1_ff.d_idx <= step.d_idx;
      rr_ff       <= RR_W'(rate) * RR_W'(ratio_val(step.r_idx));
      fits1_ff    <= ratio_fits(step.r_idx, width);
      s2_ff.first <= s1_ff.first;
      s2_ff.last  <= s1_ff.last;
      s2_ff.r_idx <= s1_ff.r_idx;
      s2_ff.d_idx <= s1_ff.d_idx;
      prod_ff     <= PROD_W'(rr_ff) * PROD_W'(div_val(s1_ff.d_idx));
      fits2_ff    <= fits1_ff;
      bd_ff       <= bd_in;
      br_ff       <= br_in;
      be_ff       <= be_in;
   end

   always_comb begin
      base_err = s2_ff.first ? MASTER_CLK : be_ff;
      in_range = prod_ff <= PROD_W'(MASTER_CLK);
      cand_err = MASTER_CLK - prod_ff[ERR_W-1:0];
      take     = s2_ff.valid && fits2_ff && in_range && (cand_err < base_err);
      bd_in    = bd_ff;
      br_in    = br_ff;
      be_in    = be_ff;
      if (take) begin
         bd_in = s2_ff.d_idx;
         br_in = s2_ff.r_idx;
         be_in = cand_err;
      end else if (s2_ff.valid && s2_ff.first) begin
         bd_in = '0;
         br_in = '0;
         be_in = MASTER_CLK;
      end
   end

   assign done       = done_ff;
   assign best_div   = bd_ff;
   assign best_ratio = br_ff;
   assign best_err   = be_ff;

endmodule

@@ tb/sv/audio_clock_divider_search_checker.sv @@
// ----------------------------------------------------------------------------
// audio_clock_divider_search_checker
// Watches the request, result and register ports of the divider search.
// For every accepted request beat it works out the best divider and ratio
// for the current sample width and queues that choice. Each result beat is
// compared field by field with the oldest queued choice.
// ----------------------------------------------------------------------------
module audio_clock_divider_search_checker
   import acds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // req_rate[19:0], zero [23:20]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // divider_index[3:0], ratio_index[7:4],
                                    // rate_error[32:8], zero [39:33]
   input  logic        csr_wen,
   input  logic [5:0]  csr_wdata,   // sample_bits[5:0]
   output int          failures,
   output int          pending
);

   typedef struct packed {
      logic [IDX_W-1:0] div_idx;
      logic [IDX_W-1:0] ratio_idx;
      logic [ERR_W-1:0] rate_error;
   } clock_choice_type;

   localparam int unsigned FRAME_RATIOS [9] = '{32, 48, 64, 96, 128, 192, 256, 384, 512};
   localparam int unsigned MCLK_DIVIDERS [13] =
      '{8, 10, 11, 15, 16, 21, 23, 30, 31, 32, 42, 63, 125};

   clock_choice_type   choices [$];
   logic [WIDTH_W-1:0] sample_bits;

   function automatic clock_choice_type best_clock_choice(input logic [RATE_W-1:0] rate,
                                                          input logic [WIDTH_W-1:0] width);
      clock_choice_type pick;
      logic [63:0]      prod;
      logic [63:0]      err;
      logic [63:0]      best;
      int unsigned      slot;
      logic             fits;
      best = 64'(MASTER_CLK);
      pick = '0;
      slot = 2 * int'(width);
      for (int r = 0; r < 9; r++) begin
         fits = (slot != 0) && (FRAME_RATIOS[r] >= slot) && (FRAME_RATIOS[r] % slot == 0);
         for (int d = 0; d < 13; d++) begin
            prod = 64'(rate) * 64'(FRAME_RATIOS[r]) * 64'(MCLK_DIVIDERS[d]);
            if (prod <= 64'(MASTER_CLK)) begin
               err = 64'(MASTER_CLK) - prod;
               if (fits && err < best) begin
                  best           = err;
                  pick.div_idx   = IDX_W'(d);
                  pick.ratio_idx = IDX_W'(r);
               end
            end
         end
      end
      pick.rate_error = ERR_W'(best);
      return pick;
   endfunction

   always @(posedge clock) begin
      clock_choice_type want;
      clock_choice_type got;
      if (reset) begin
         choices.delete();
         sample_bits = WIDTH_RESET;
         failures    = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.div_idx    = rsp_tdata[3:0];
            got.ratio_idx  = rsp_tdata[7:4];
            got.rate_error = rsp_tdata[32:8];
            if (choices.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected result beat: div %0d ratio %0d err %0d",
                           got.div_idx, got.ratio_idx, got.rate_error);
            end else begin
               want = choices.pop_front();
               if (got.div_idx !== want.div_idx || got.ratio_idx !== want.ratio_idx ||
                   got.rate_error !== want.rate_error) begin
                  failures++;
                  if (failures <= 10)
                     $display({"mismatch: expected div %0d ratio %0d err %0d, ",
                               "got div %0d ratio %0d err %0d"},
                              want.div_idx, want.ratio_idx, want.rate_error,
                              got.div_idx, got.ratio_idx, got.rate_error);
               end
            end
         end
         if (req_tvalid && req_tready)
            choices.push_back(best_clock_choice(req_tdata[RATE_W-1:0], sample_bits));
         if (csr_wen)
            sample_bits = csr_wdata;
      end
      pending = choices.size();
   end

endmodule

@@ tb/sv/audio_clock_divider_search_test.sv @@
// ----------------------------------------------------------------------------
// audio_clock_divider_search_test
// Drives sample rate requests into the divider search under a series of
// sample widths, from zero and one up to the 6-bit maximum, with random
// gaps on the request side and random stalls on the result side. A checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module audio_clock_divider_search_test;
   import acds_pkg::*;

   localparam logic [5:0] WIDTH_PLAN [16] =
      '{6'd0, 6'd1, 6'd63, 6'd32, 6'd24, 6'd2, 6'd3, 6'd48,
        6'd8, 6'd5, 6'd33, 6'd12, 6'd6, 6'd4, 6'd16, 6'd40};
   localparam int unsigned AUDIO_RATES [11] =
      '{8000, 11025, 16000, 22050, 32000, 44100, 48000, 88200, 96000, 176400, 192000};
   localparam int unsigned EDGE_RATES [18] =
      '{0, 1, 2, 3, 1048575, 125000, 125001, 62500, 8000, 7999,
        44100, 48000, 96000, 192000, 524288, 349525, 699050, 1000};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // req_rate[19:0], zero [23:20]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // divider_index[3:0], ratio_index[7:4],
                             // rate_error[32:8], zero [39:33]
   logic        csr_wen;
   logic [5:0]  csr_wdata;   // sample_bits[5:0]
   logic        calm;
   int          failures;
   int          pending;

   audio_clock_divider_search i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   audio_clock_divider_search_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .failures   (failures),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 40)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 4);
      else if (roll < 97)
         return $urandom_range(5, 30);
      else
         return $urandom_range(50, 200);
   endfunction

   function automatic logic [19:0] pick_rate();
      int unsigned ratio;
      int unsigned div;
      int unsigned hit;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return 20'($urandom_range(1, 125000));
         6:                return 20'(AUDIO_RATES[$urandom_range(0, 10)]);
         7:                return 20'($urandom);
         default: begin
            ratio = 32 << $urandom_range(0, 4);
            if ($urandom_range(0, 1))
               ratio = ratio * 3 / 2;
            div = $urandom_range(8, 125);
            hit = 32000000 / (ratio * div);
            return 20'(hit + $urandom_range(0, 2) - 1);
         end
      endcase
   endfunction

   task automatic send_rate(input logic [19:0] rate);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {4'b0, rate};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic set_width(input logic [5:0] width);
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      csr_wen   = 1'b1;
      csr_wdata = width;
      @(negedge clock);
      csr_wen   = 1'b0;
   endtask

   // result side: ready stretches broken by random stalls
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         int unsigned stall;
         rsp_tready = 1'b1;
         repeat ($urandom_range(1, 40)) @(negedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   initial begin
      logic [5:0] width;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wen    = 1'b0;
      csr_wdata  = '0;
      calm       = 1'b0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      foreach (EDGE_RATES[i])
         send_rate(20'(EDGE_RATES[i]));

      for (int phase = 0; phase < 20; phase++) begin
         width = (phase < 16) ? WIDTH_PLAN[phase] : 6'($urandom_range(0, 63));
         set_width(width);
         calm = ($urandom_range(0, 3) == 0);
         repeat (85) send_rate(pick_rate());
      end
      req_tvalid = 1'b0;
      calm       = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (failures == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
